FILE: rtl/telegram_byte_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// Telegram byte deframer assertion macros
// Shared concurrent assertion forms used by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef TELEGRAM_BYTE_DEFRAMER_UNIT_MACROS_SVH
`define TELEGRAM_BYTE_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tbd_pkg.sv
// ----------------------------------------------------------------------------
// Telegram byte deframer package
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package tbd_pkg;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int CFG_INDEX_W = 1;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h68;
	localparam logic [BYTE_W-1:0] STOP_MARKER_RST  = 8'h16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STOP_MARKER  = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_COT  = 3'd2,
		PH_ID   = 3'd3,
		PH_IOB  = 3'd4,
		PH_DATA = 3'd5,
		PH_STOP = 3'd6
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] frame_length;
		logic [BYTE_W-1:0] cause_code;
		logic [BYTE_W-1:0] message_id;
		logic [BYTE_W-1:0] info_byte;
		logic              last;
	} result_t;

endpackage

FILE: rtl/tbd_parser.sv
// ----------------------------------------------------------------------------
// Telegram byte deframer parser
// Frame state machine, header capture and marker registers.
// ----------------------------------------------------------------------------
`include "telegram_byte_deframer_unit_macros.svh"

module tbd_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tbd_pkg::BYTE_W-1:0]         cfg_wdata,
	input  logic                               accept,
	input  logic [tbd_pkg::BYTE_W-1:0]         rx_byte,
	output logic                               res_valid,
	output tbd_pkg::result_t                   res
);

	tbd_pkg::phase_t             phase_q, phase_d;
	logic [tbd_pkg::BYTE_W-1:0]  start_marker_q, stop_marker_q;
	logic [tbd_pkg::BYTE_W-1:0]  length_q, cause_q, ident_q, info_q, count_q;
	logic [tbd_pkg::BYTE_W-1:0]  count_inc;

	assign count_inc = count_q + 8'd1;

	// Marker registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= tbd_pkg::START_MARKER_RST;
			stop_marker_q  <= tbd_pkg::STOP_MARKER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbd_pkg::CFG_START_MARKER: start_marker_q <= cfg_wdata;
				tbd_pkg::CFG_STOP_MARKER:  stop_marker_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			tbd_pkg::PH_LEN:  phase_d = tbd_pkg::PH_COT;
			tbd_pkg::PH_COT:  phase_d = tbd_pkg::PH_ID;
			tbd_pkg::PH_ID:   phase_d = tbd_pkg::PH_IOB;
			tbd_pkg::PH_IOB:  phase_d = (length_q == '0) ? tbd_pkg::PH_STOP : tbd_pkg::PH_DATA;
			tbd_pkg::PH_DATA: phase_d = (count_inc >= length_q) ? tbd_pkg::PH_STOP
			                                                     : tbd_pkg::PH_DATA;
			tbd_pkg::PH_STOP: phase_d = tbd_pkg::PH_HUNT;
			default:          phase_d = (rx_byte == start_marker_q) ? tbd_pkg::PH_LEN
			                                                        : tbd_pkg::PH_HUNT;
		endcase
	end

	// Result for the byte being transferred in.
	always_comb begin
		res_valid         = 1'b0;
		res.kind          = tbd_pkg::KIND_PAYLOAD;
		res.payload_byte  = '0;
		res.payload_index = '0;
		res.frame_length  = length_q;
		res.cause_code    = cause_q;
		res.message_id    = ident_q;
		res.info_byte     = info_q;
		res.last          = 1'b0;
		unique case (phase_q)
			tbd_pkg::PH_DATA: begin
				res_valid         = accept;
				res.payload_byte  = rx_byte;
				res.payload_index = count_q;
			end
			tbd_pkg::PH_STOP: begin
				res_valid = accept;
				res.kind  = (rx_byte == stop_marker_q) ? tbd_pkg::KIND_GOOD : tbd_pkg::KIND_BAD;
				res.last  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tbd_pkg::PH_HUNT;
			length_q <= '0;
			cause_q  <= '0;
			ident_q  <= '0;
			info_q   <= '0;
			count_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			unique case (phase_q)
				tbd_pkg::PH_LEN:  length_q <= rx_byte;
				tbd_pkg::PH_COT:  cause_q  <= rx_byte;
				tbd_pkg::PH_ID:   ident_q  <= rx_byte;
				tbd_pkg::PH_IOB: begin
					info_q  <= rx_byte;
					count_q <= '0;
				end
				tbd_pkg::PH_DATA: count_q <= count_inc;
				default: ;
			endcase
		end
	end

	`TBD_ASSERT_NOW(a_res_needs_accept, res_valid, accept,
		"result produced without an input transfer")
	`TBD_ASSERT_NOW(a_end_is_last, res_valid && res.kind != tbd_pkg::KIND_PAYLOAD,
		res.last, "end result without last flag")
	`TBD_ASSERT_NEXT(a_stop_to_hunt, accept && phase_q == tbd_pkg::PH_STOP,
		phase_q == tbd_pkg::PH_HUNT, "stop byte did not return to hunting")
	`TBD_ASSERT_NOW(a_data_index_in_range, res_valid && !res.last,
		res.payload_index < res.frame_length, "payload index beyond frame length")

endmodule

FILE: rtl/tbd_out_reg.sv
// ----------------------------------------------------------------------------
// Telegram byte deframer output register
// Result register with one skid entry so input and output stall independently.
// ----------------------------------------------------------------------------
`include "telegram_byte_deframer_unit_macros.svh"

module tbd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tbd_pkg::result_t push_data,
	output logic             ready,
	output logic             m_valid,
	input  logic             m_ready,
	output tbd_pkg::result_t m_data
);

	logic             main_valid_q, skid_valid_q;
	tbd_pkg::result_t main_q, skid_q;
	logic             pop;

	assign pop     = main_valid_q && m_ready;
	assign ready   = !skid_valid_q;
	assign m_valid = main_valid_q;
	assign m_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q || pop) begin
				main_valid_q <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end
		if (push && main_valid_q && !pop) begin
			skid_q <= push_data;
		end
	end

	`TBD_ASSERT_NOW(a_skid_implies_main, skid_valid_q, main_valid_q,
		"skid entry held while result register empty")
	`TBD_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_q,
		"result pushed while both entries full")
	`TBD_ASSERT_NEXT(a_stall_holds, main_valid_q && !m_ready, main_valid_q,
		"stalled result dropped")

endmodule

FILE: rtl/telegram_byte_deframer_unit.sv
// ----------------------------------------------------------------------------
// Telegram byte deframer
// Start/length/stop byte frame parser streaming payload and frame verdicts.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the s_ channel, one byte per transfer. The
// block hunts for the start marker, captures the length, cause, identifier
// and info header bytes, then streams each payload byte out on the m_
// channel with its index and the header fields. The byte after the payload
// is compared with the stop marker and yields an end result (tuser kind good
// or bad) with tlast high. Payload leaves before the verdict, so a consumer
// must drop the payload of a frame that ends bad.
// Throughput is one input byte per cycle while s_tready is high. Each result
// is registered in the output register, or the skid entry if the receiver
// stalls, once its byte is transferred in; header and hunted bytes give none.
// The frame state is one register set updated on each input transfer. Reset
// clears it to hunting and loads the markers with 0x68 and 0x16. When the
// receiver stalls, one result waits in the output register and a second in a
// skid entry; s_tready drops only while both are occupied. The user must write
// markers over cfg_we/cfg_index/cfg_wdata only while idle; not enforced.
// ----------------------------------------------------------------------------
module telegram_byte_deframer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [tbd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tbd_pkg::BYTE_W-1:0]      cfg_wdata,
	// Input byte stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [47:0]                     m_tdata,   // [7:0] payload_byte,
	                                                   // [15:8] payload_index,
	                                                   // [23:16] frame_length,
	                                                   // [31:24] cause_code,
	                                                   // [39:32] message_id,
	                                                   // [47:40] info_byte
	output logic [1:0]                      m_tuser,   // [1:0] kind
	output logic                            m_tlast    // last
);

	logic             accept;
	logic             res_valid;
	tbd_pkg::result_t res;
	tbd_pkg::result_t out_data;

	// A byte transfer happens whenever s_tvalid is high and the skid entry is free.
	assign accept = s_tvalid && s_tready;

	tbd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.rx_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	tbd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.ready     (s_tready),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_data    (out_data)
	);

	// Pack the result onto the stream fields, first field in the low bits.
	assign m_tdata = {out_data.info_byte, out_data.message_id, out_data.cause_code,
	                  out_data.frame_length, out_data.payload_index, out_data.payload_byte};
	assign m_tuser = out_data.kind;
	assign m_tlast = out_data.last;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Telegram byte deframer testbench
// Drives received bytes into the deframer under changing markers and idling,
// predicts every payload and verdict transfer, and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;

	// Length of the single receiver hold-off, during which the output
	// register and the skid entry fill and the block pushes back on input.
	localparam int HOLD_CYCLES = 300;
	// Settling wait after the last verdict before touching the markers
	// or ending the run.
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [tbd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tbd_pkg::BYTE_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	// Bytes waiting to be sent; the head is the byte on offer.
	logic [7:0] pending_bytes[$];
	// Results the parser must still produce, oldest first.
	tbd_pkg::result_t expected_results[$];

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int failures = 0;
	bit in_taken = 1'b0;

	// Our own copy of the marker registers and of the frame state.
	logic [7:0] start_mark = tbd_pkg::START_MARKER_RST;
	logic [7:0] stop_mark = tbd_pkg::STOP_MARKER_RST;
	tbd_pkg::phase_t frame_phase = tbd_pkg::PH_HUNT;
	logic [7:0] len_hold = '0;
	logic [7:0] cause_hold = '0;
	logic [7:0] ident_hold = '0;
	logic [7:0] info_hold = '0;
	logic [7:0] data_count = '0;

	telegram_byte_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // [7:0] rx_byte
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),     // [7:0] payload_byte, [15:8] payload_index,
		                       // [23:16] frame_length, [31:24] cause_code,
		                       // [39:32] message_id, [47:40] info_byte
		.m_tuser(m_tuser),     // [1:0] kind
		.m_tlast(m_tlast)      // last
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advances the frame parser by one received byte and queues the result
	// that byte causes, if any. Header and hunted bytes cause none.
	task automatic deframe_byte(input logic [7:0] rx);
		tbd_pkg::result_t res;
		res = '0;
		res.frame_length = len_hold;
		res.cause_code = cause_hold;
		res.message_id = ident_hold;
		res.info_byte = info_hold;
		case (frame_phase)
			tbd_pkg::PH_LEN: begin
				len_hold = rx;
				frame_phase = tbd_pkg::PH_COT;
			end
			tbd_pkg::PH_COT: begin
				cause_hold = rx;
				frame_phase = tbd_pkg::PH_ID;
			end
			tbd_pkg::PH_ID: begin
				ident_hold = rx;
				frame_phase = tbd_pkg::PH_IOB;
			end
			tbd_pkg::PH_IOB: begin
				info_hold = rx;
				data_count = '0;
				// An empty payload goes straight to the stop byte.
				frame_phase = (len_hold == 8'd0) ? tbd_pkg::PH_STOP : tbd_pkg::PH_DATA;
			end
			tbd_pkg::PH_DATA: begin
				res.kind = tbd_pkg::KIND_PAYLOAD;
				res.payload_byte = rx;
				res.payload_index = data_count;
				expected_results.push_back(res);
				data_count = data_count + 8'd1;
				if (data_count >= len_hold)
					frame_phase = tbd_pkg::PH_STOP;
			end
			tbd_pkg::PH_STOP: begin
				// A wrong stop byte closes the frame as bad and is not looked
				// at again as a possible start marker.
				res.kind = (rx == stop_mark) ? tbd_pkg::KIND_GOOD : tbd_pkg::KIND_BAD;
				res.last = 1'b1;
				expected_results.push_back(res);
				frame_phase = tbd_pkg::PH_HUNT;
			end
			default: begin
				frame_phase = (rx == start_mark) ? tbd_pkg::PH_LEN : tbd_pkg::PH_HUNT;
			end
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			failures++;
		end
	endtask

	// Monitor. The input transfer of this edge is predicted first, then the
	// output transfer of the same edge is checked against the oldest entry.
	always @(posedge clk) begin
		tbd_pkg::result_t want;
		if (arst_n) begin
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				deframe_byte(s_tdata);
				void'(pending_bytes.pop_front());
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, %s %0d data %h last %b",
						$time, "actual kind", m_tuser, m_tdata, m_tlast);
					failures++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", int'(want.kind), int'(m_tuser));
					check_field("payload_byte", int'(want.payload_byte), int'(m_tdata[7:0]));
					check_field("payload_index", int'(want.payload_index),
						int'(m_tdata[15:8]));
					check_field("frame_length", int'(want.frame_length), int'(m_tdata[23:16]));
					check_field("cause_code", int'(want.cause_code), int'(m_tdata[31:24]));
					check_field("message_id", int'(want.message_id), int'(m_tdata[39:32]));
					check_field("info_byte", int'(want.info_byte), int'(m_tdata[47:40]));
					check_field("last", int'(want.last), int'(m_tlast));
				end
			end
		end
	end

	// Byte driver. A byte on offer stays until its transfer; otherwise the
	// head of the queue is offered unless the sender idles this cycle.
	always @(negedge clk) begin
		if (!arst_n)
			s_tvalid <= 1'b0;
		else if (s_tvalid && !in_taken)
			s_tvalid <= 1'b1;
		else if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
			s_tvalid <= 1'b1;
			s_tdata <= pending_bytes[0];
		end else
			s_tvalid <= 1'b0;
	end

	// Long receiver hold-off, started once per request from the stimulus.
	always @(negedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_done != hold_req) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= hold_req;
		end
	end

	always @(negedge clk)
		m_tready <= arst_n && hold_left == 0 && hold_done == hold_req &&
			$urandom_range(99) >= snk_stall_pct;

	// Marker writes happen only while nothing is in flight, so the local
	// copies can be updated right after the write.
	task automatic write_marker(input logic [tbd_pkg::CFG_INDEX_W-1:0] idx,
		input logic [7:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == tbd_pkg::CFG_START_MARKER)
			start_mark = val;
		else
			stop_mark = val;
	endtask

	task automatic drain;
		while (pending_bytes.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One whole frame under the current markers, with random header and
	// payload. A bad frame gets a stop byte that differs from the marker.
	task automatic queue_frame(input int len, input bit good);
		logic [7:0] close_byte;
		pending_bytes.push_back(start_mark);
		pending_bytes.push_back(len[7:0]);
		repeat (3) pending_bytes.push_back(8'($urandom_range(255)));
		repeat (len) pending_bytes.push_back(8'($urandom_range(255)));
		if (good)
			close_byte = stop_mark;
		else begin
			do close_byte = 8'($urandom_range(255));
			while (close_byte == stop_mark);
		end
		pending_bytes.push_back(close_byte);
	endtask

	// Mostly well-formed frames with short payloads, some long and a few of
	// the full 255 bytes, mixed with line noise and frames cut off early.
	task automatic queue_traffic(input int frame_bytes);
		int sent;
		int roll;
		int len;
		logic [7:0] junk;
		sent = 0;
		while (sent < frame_bytes) begin
			roll = $urandom_range(99);
			if (roll < 8)
				repeat ($urandom_range(4, 1)) pending_bytes.push_back(8'($urandom_range(255)));
			else if (roll < 14) begin
				// Truncated frame: the next bytes are swallowed as its rest.
				pending_bytes.push_back(start_mark);
				repeat ($urandom_range(4, 1)) pending_bytes.push_back(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(2)) begin
					do junk = 8'($urandom_range(255));
					while (junk == start_mark);
					pending_bytes.push_back(junk);
				end
				roll = $urandom_range(99);
				if (roll < 1)
					len = 255;
				else if (roll < 6)
					len = $urandom_range(255);
				else
					len = $urandom_range(8);
				queue_frame(len, $urandom_range(9) != 0);
				sent += len + 6;
			end
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset markers 0x68 and 0x16.
		pending_bytes = '{8'h00, 8'hFF,
			// Empty payload, header bytes at both extremes, good stop.
			8'h68, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h16,
			// Start marker inside header and payload, bad stop byte that is
			// itself the start marker and must not open a frame.
			8'h68, 8'h02, 8'h68, 8'h00, 8'hFF, 8'h68, 8'h00, 8'h68,
			// Dropped byte, then a one-byte frame that closes good.
			8'h02, 8'h68, 8'h01, 8'hAA, 8'h55, 8'h00, 8'h7F, 8'h16};
		drain();

		// No idling, markers at the low and high extremes.
		write_marker(tbd_pkg::CFG_START_MARKER, 8'h00);
		write_marker(tbd_pkg::CFG_STOP_MARKER, 8'hFF);
		queue_traffic(380);
		drain();

		// Sender idles often, markers swapped to the other extremes.
		src_idle_pct = 46;
		write_marker(tbd_pkg::CFG_START_MARKER, 8'hFF);
		write_marker(tbd_pkg::CFG_STOP_MARKER, 8'h00);
		queue_traffic(380);
		drain();

		// Receiver stalls often, random markers.
		src_idle_pct = 0;
		snk_stall_pct = 46;
		write_marker(tbd_pkg::CFG_START_MARKER, 8'($urandom_range(255)));
		write_marker(tbd_pkg::CFG_STOP_MARKER, 8'($urandom_range(255)));
		queue_traffic(380);
		drain();

		// Both sides idle, start and stop markers equal.
		src_idle_pct = 35;
		snk_stall_pct = 35;
		write_marker(tbd_pkg::CFG_START_MARKER, 8'($urandom_range(255)));
		write_marker(tbd_pkg::CFG_STOP_MARKER, start_mark);
		queue_traffic(380);
		drain();

		// Back-pressure: the receiver holds off while a long frame streams
		// in at full rate, so the block has to stall its input.
		src_idle_pct = 0;
		snk_stall_pct = 0;
		write_marker(tbd_pkg::CFG_START_MARKER, tbd_pkg::START_MARKER_RST);
		write_marker(tbd_pkg::CFG_STOP_MARKER, tbd_pkg::STOP_MARKER_RST);
		@(posedge clk);
		hold_req = hold_req + 1;
		queue_frame(200, 1'b1);
		queue_traffic(60);
		drain();

		if (failures == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule
